// ===== rtl/fdfp_pkg.sv =====
// Shared constants for the framed decimal field parser.
// Used by the channel interfaces and the top level; no dependencies.
package fdfp_pkg;

  // Payload widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned FramePosW = 6;
  localparam int unsigned FieldLenW = 5;

  // Framing characters
  localparam logic [ByteW-1:0] CharOpen  = 8'h25;  // '%'
  localparam logic [ByteW-1:0] CharClose = 8'h26;  // '&'
  localparam logic [ByteW-1:0] CharSep   = 8'h3A;  // ':'
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;  // '-'
  localparam logic [ByteW-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CharNul   = 8'h00;

endpackage

// ===== rtl/fdfp_byte_if.sv =====
// Valid/ready channel carrying one received byte.
// Depends on fdfp_pkg for the byte width.
interface fdfp_byte_if;
  import fdfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/fdfp_result_if.sv =====
// Valid/ready channel carrying one parser result.
// Depends on fdfp_pkg for the field widths.
interface fdfp_result_if;
  import fdfp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ByteW-1:0]         option_code;
  logic signed [ValueW-1:0] value;
  logic [IndexW-1:0]        value_index;
  logic                     value_valid;
  logic                     frame_end;

  modport source (output valid, output option_code, output value, output value_index,
                  output value_valid, output frame_end, input ready);
  modport sink   (input valid, input option_code, input value, input value_index,
                  input value_valid, input frame_end, output ready);
endinterface

// ===== rtl/framed_decimal_field_parser.sv =====
// Framed decimal field parser: '%'-opened, '&'-closed frames of ':'-separated fields.
// Depends on fdfp_pkg, fdfp_byte_if and fdfp_result_if.
//
// The parser takes one byte per clock cycle unless a result is held back on the
// result channel. A byte is captured in an input register. When the byte is
// processed, the frame state (position, field length, sign, accumulator, value
// count, option byte) is updated by a single pass of logic: one multiply-by-ten
// add, a negate and a few compares. A result, if the byte causes one, is loaded
// into the output register in that same cycle, so a result passes the input
// register and then the output register. While a result waits on the result
// channel, the input register can take one byte and hold it; after that the
// input channel stalls until the result transfers. Bytes past MAX_LEN in a frame,
// field bytes past FIELD_MAX and zero bytes are dropped. No reset sweep is needed.
module framed_decimal_field_parser #(
  parameter int unsigned MAX_LEN   = 32,
  parameter int unsigned FIELD_MAX = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fdfp_byte_if.sink            rx_i,
  fdfp_result_if.source        res_o
);
  import fdfp_pkg::*;

  localparam logic [FramePosW-1:0] MaxLen   = FramePosW'(MAX_LEN);
  localparam logic [FieldLenW-1:0] FieldMax = FieldLenW'(FIELD_MAX);

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // Frame state
  logic                 in_frame_q,  in_frame_d;
  logic [FramePosW-1:0] frame_pos_q, frame_pos_d;
  logic [FieldLenW-1:0] field_len_q, field_len_d;
  logic                 field_neg_q, field_neg_d;
  logic [ValueW-1:0]    acc_q,       acc_d;
  logic [IndexW-1:0]    value_cnt_q, value_cnt_d;
  logic [ByteW-1:0]     option_q,    option_d;

  // Result register
  logic                     out_valid_q;
  logic [ByteW-1:0]         out_option_q;
  logic signed [ValueW-1:0] out_value_q;
  logic [IndexW-1:0]        out_index_q;
  logic                     out_vvalid_q;
  logic                     out_end_q;

  // Result of the current byte
  logic                     emit;
  logic signed [ValueW-1:0] emit_value;
  logic [IndexW-1:0]        emit_index;
  logic                     emit_vvalid;
  logic                     emit_end;

  logic              advance;
  logic [ValueW-1:0] field_value;
  logic [ValueW-1:0] acc_next;

  // Process the held byte when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  assign field_value = field_neg_q ? (ValueW'(0) - acc_q) : acc_q;
  assign acc_next    = (acc_q << 3) + (acc_q << 1) + ValueW'(in_byte_q) - ValueW'(CharZero);

  // Frame state update for one byte
  always_comb begin
    in_frame_d  = in_frame_q;
    frame_pos_d = frame_pos_q;
    field_len_d = field_len_q;
    field_neg_d = field_neg_q;
    acc_d       = acc_q;
    value_cnt_d = value_cnt_q;
    option_d    = option_q;
    emit        = 1'b0;
    emit_value  = '0;
    emit_index  = '0;
    emit_vvalid = 1'b0;
    emit_end    = 1'b0;

    if (!in_frame_q) begin
      // Outside a frame: wait for the opening byte
      if (in_byte_q == CharOpen) begin
        in_frame_d  = 1'b1;
        frame_pos_d = '0;
        value_cnt_d = '0;
        option_d    = '0;
        field_len_d = '0;
        field_neg_d = 1'b0;
        acc_d       = '0;
      end
    end else if (in_byte_q == CharClose) begin
      // Close the frame, carry the last field if the frame holds enough bytes
      emit        = 1'b1;
      emit_end    = 1'b1;
      emit_vvalid = (frame_pos_q >= FramePosW'(2));
      if (emit_vvalid) begin
        emit_value = field_value;
        emit_index = value_cnt_q;
      end
      in_frame_d  = 1'b0;
      frame_pos_d = '0;
      value_cnt_d = '0;
      option_d    = '0;
      field_len_d = '0;
      field_neg_d = 1'b0;
      acc_d       = '0;
    end else if (in_byte_q != CharNul && frame_pos_q < MaxLen) begin
      frame_pos_d = frame_pos_q + FramePosW'(1);
      if (frame_pos_q == FramePosW'(0)) begin
        option_d = in_byte_q;
      end else if (frame_pos_q == FramePosW'(1)) begin
        // Skip the second frame byte
      end else if (in_byte_q == CharSep) begin
        // Field separator: emit and start a new field
        emit        = 1'b1;
        emit_vvalid = 1'b1;
        emit_value  = field_value;
        emit_index  = value_cnt_q;
        field_len_d = '0;
        field_neg_d = 1'b0;
        acc_d       = '0;
        value_cnt_d = value_cnt_q + IndexW'(1);
      end else if (field_len_q < FieldMax) begin
        if (in_byte_q == CharMinus && field_len_q == '0) begin
          field_neg_d = 1'b1;
        end else begin
          acc_d = acc_next;
        end
        field_len_d = field_len_q + FieldLenW'(1);
      end
    end
  end

  // Hold the incoming byte until it is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Advance the frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      frame_pos_q <= '0;
      field_len_q <= '0;
      field_neg_q <= 1'b0;
      acc_q       <= '0;
      value_cnt_q <= '0;
      option_q    <= '0;
    end else if (advance) begin
      in_frame_q  <= in_frame_d;
      frame_pos_q <= frame_pos_d;
      field_len_q <= field_len_d;
      field_neg_q <= field_neg_d;
      acc_q       <= acc_d;
      value_cnt_q <= value_cnt_d;
      option_q    <= option_d;
    end
  end

  // Result valid: load on advance, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_option_q <= option_q;
      out_value_q  <= emit_value;
      out_index_q  <= emit_index;
      out_vvalid_q <= emit_vvalid;
      out_end_q    <= emit_end;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.option_code = out_option_q;
  assign res_o.value       = out_value_q;
  assign res_o.value_index = out_index_q;
  assign res_o.value_valid = out_vvalid_q;
  assign res_o.frame_end   = out_end_q;

endmodule
